// ===== hw/rtl/llk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llk_pkg
// shared types, constants and helpers for the leg linkage kinematics pipeline
// ----------------------------------------------------------------------------
package llk_pkg;

	// pi scaled by 2^32, rounded to nearest
	localparam longint PI_Q32 = 64'sd13493037705;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

	// fixed field widths
	localparam int ANG_W = 24;
	localparam int MEAN_W = 22;    // holds pi up to the widest fraction setting
	localparam int EXT_W = 18;
	localparam int TRQ_W = 32;
	localparam int CFG_W = 16;
	localparam int ROOT_W = 30;
	localparam int ARG_W = 2 * ROOT_W;
	localparam int NUM_W = 62;
	localparam int TRIG_W = 34;

	typedef enum logic [1:0] {
		REG_UPPER_LEN   = 2'd0,
		REG_LOWER_LEN   = 2'd1,
		REG_LENGTH_MODE = 2'd2
	} cfg_reg_t;

	// fields that ride along the whole pipe
	typedef struct packed {
		logic signed [ANG_W-1:0] diff;
		logic [EXT_W-1:0]        mean_lo;
		logic signed [ANG_W-1:0] fe;
		logic signed [ANG_W-1:0] fa;
	} side_t;

	// carried through the root stages
	typedef struct packed {
		logic                     neg;
		logic signed [62:0]       psc;
		logic signed [TRIG_W-1:0] l1s;
		logic signed [TRIG_W-1:0] l1c;
		side_t                    side;
	} mid_t;

	// carried through the divider stages
	typedef struct packed {
		logic [ROOT_W-1:0]        root;
		logic                     psgn;
		logic                     fault;
		logic [EXT_W-1:0]         ext;
		logic signed [TRIG_W-1:0] l1s;
		side_t                    side;
	} tail_t;

	// arctangent of 2^-i in Q30
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// saturate a 36-bit sum to 32 bits
	function automatic logic [TRQ_W-1:0] sat32(input logic signed [35:0] v);
		logic [TRQ_W-1:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'h7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'h80000000;
		end else begin
			r = v[TRQ_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/leg_linkage_kinematics_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leg_linkage_kinematics_top
// two-joint leg kinematics: angle fold, cordic trig, root and jacobian force map
// ----------------------------------------------------------------------------
//
// channel   dir  width  contents
// s_axis    in   96     joint_angle_a, joint_angle_b, force_extension, force_angle
// m_axis    out  112    toe_extension, toe_angle, torque_first, torque_second, fault
// cfg       in   2+16   upper_link_length, lower_link_length, length_mode
//
// one transaction enters per cycle while the output register is empty or taken; the
//   stages in order are the angle fold (5), cordic rotations, products (3), a bit-per-stage
//   root (30), extension and divider setup (1), a bit-per-stage jacobian divider (62),
//   force map (3) and the output register
// all stages advance together whenever the output register is empty or taken
// a stall freezes the whole pipe; valid bits move with the data
// reset clears only the valid line and sets the config registers to their defaults
//
module leg_linkage_kinematics_top #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STAGES = 18
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// joint_angle_a[23:0], joint_angle_b[47:24], force_extension[71:48],
	// force_angle[95:72]
	input  wire logic [95:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// toe_extension[17:0], toe_angle[41:18], torque_first[73:42],
	// torque_second[105:74], fault[106], zero[111:107]
	output logic [111:0]      m_tdata,
	input  wire logic         cfg_wen,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	localparam int F = ANGLE_FRAC_BITS;
	localparam int NC = CORDIC_STAGES;
	localparam int AW = llk_pkg::ANG_W;
	localparam int TW = llk_pkg::TRIG_W;
	localparam int RW = llk_pkg::ROOT_W;
	localparam int NW = llk_pkg::NUM_W;
	localparam int LAT = NC + 105;

	// angle constants at the chosen fraction
	localparam longint PI_L = (llk_pkg::PI_Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F);
	localparam logic [AW-1:0] PI = AW'(PI_L);
	localparam logic [AW-1:0] TWO_PI = AW'(2 * PI_L);
	// reciprocals for the modulo, quotient estimate low by at most one
	localparam logic [31:0] RCP_PI = 32'((64'sd1 <<< 32) / PI_L);
	localparam logic [31:0] RCP_2PI = 32'((64'sd1 <<< 32) / (2 * PI_L));
	localparam int SH30 = 30 - F;

	// ---------------- config registers ----------------
	logic [15:0] upl_q, lwl_q;
	logic        mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upl_q  <= 16'd6554;
			lwl_q  <= 16'd13107;
			mode_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				llk_pkg::REG_UPPER_LEN:   upl_q  <= cfg_data;
				llk_pkg::REG_LOWER_LEN:   lwl_q  <= cfg_data;
				llk_pkg::REG_LENGTH_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic adv;
	logic vld_s [LAT];

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---------------- s1: half difference and sums ----------------
	logic signed [AW-1:0] ang_a, ang_b, f_ext, f_ang;
	logic signed [AW:0]   dab;
	logic signed [AW-1:0] diff_c;
	logic signed [25:0]   sm_c, v_c;

	assign ang_a = $signed(s_tdata[23:0]);
	assign ang_b = $signed(s_tdata[47:24]);
	assign f_ext = $signed(s_tdata[71:48]);
	assign f_ang = $signed(s_tdata[95:72]);
	assign dab = $signed({ang_a[AW-1], ang_a}) - $signed({ang_b[AW-1], ang_b});
	assign diff_c = dab[AW:1];
	assign sm_c = $signed({{2{ang_b[AW-1]}}, ang_b}) + $signed({{2{diff_c[AW-1]}}, diff_c});
	assign v_c = $signed({{2{diff_c[AW-1]}}, diff_c}) + $signed({2'b00, TWO_PI});

	logic signed [AW-1:0] diff_s1, fe_s1, fa_s1;
	logic signed [25:0]   sm_s1, v_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= diff_c;
			sm_s1   <= sm_c;
			v_s1    <= v_c;
			fe_s1   <= f_ext;
			fa_s1   <= f_ang;
		end
	end

	// ---------------- s2: quotient estimates ----------------
	logic [25:0] msm_c, mv_c;
	logic [57:0] qs_prod, qv_prod;

	assign msm_c = sm_s1[25] ? 26'(-sm_s1) : 26'(sm_s1);
	assign mv_c = v_s1[25] ? 26'(-v_s1) : 26'(v_s1);
	assign qs_prod = 58'(msm_c) * 58'(RCP_PI);
	assign qv_prod = 58'(mv_c) * 58'(RCP_2PI);

	logic [25:0]          msm_s2, mv_s2, qs_s2, qv_s2;
	logic                 ssm_s2, sv_s2;
	logic signed [AW-1:0] diff_s2, fe_s2, fa_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			msm_s2  <= msm_c;
			mv_s2   <= mv_c;
			qs_s2   <= qs_prod[57:32];
			qv_s2   <= qv_prod[57:32];
			ssm_s2  <= sm_s1[25];
			sv_s2   <= v_s1[25];
			diff_s2 <= diff_s1;
			fe_s2   <= fe_s1;
			fa_s2   <= fa_s1;
		end
	end

	// ---------------- s3: first remainders ----------------
	logic [49:0] ps_c, pv_c;

	assign ps_c = 50'(qs_s2) * 50'(PI);
	assign pv_c = 50'(qv_s2) * 50'(TWO_PI);

	logic [25:0]          rs_s3, rv_s3;
	logic                 ssm_s3, sv_s3;
	logic signed [AW-1:0] diff_s3, fe_s3, fa_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			rs_s3   <= 26'(50'(msm_s2) - ps_c);
			rv_s3   <= 26'(50'(mv_s2) - pv_c);
			ssm_s3  <= ssm_s2;
			sv_s3   <= sv_s2;
			diff_s3 <= diff_s2;
			fe_s3   <= fe_s2;
			fa_s3   <= fa_s2;
		end
	end

	// ---------------- s4: remainder correction ----------------
	logic [25:0]          rs_c, rv_c;
	logic signed [AW-1:0] meanr_c;
	logic [AW-1:0]        w_c;

	assign rs_c = (rs_s3 >= 26'(PI)) ? rs_s3 - 26'(PI) : rs_s3;
	assign rv_c = (rv_s3 >= 26'(TWO_PI)) ? rv_s3 - 26'(TWO_PI) : rv_s3;
	assign meanr_c = ssm_s3 ? -$signed(rs_c[AW-1:0]) : $signed(rs_c[AW-1:0]);
	// floored modulo of a negative value
	assign w_c = !sv_s3 ? rv_c[AW-1:0] :
		(rv_c == 26'd0) ? '0 : TWO_PI - rv_c[AW-1:0];

	logic signed [AW-1:0] meanr_s4, diff_s4, fe_s4, fa_s4;
	logic [AW-1:0]        w_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			meanr_s4 <= meanr_c;
			w_s4     <= w_c;
			diff_s4  <= diff_s3;
			fe_s4    <= fe_s3;
			fa_s4    <= fa_s3;
		end
	end

	// ---------------- s5: fold mean into [0,pi) ----------------
	logic [llk_pkg::MEAN_W-1:0] mean_s5;
	llk_pkg::side_t             side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5.fe <= fe_s4;
			side_s5.fa <= fa_s4;
			if (meanr_s4[AW-1]) begin
				mean_s5      <= llk_pkg::MEAN_W'(meanr_s4 + $signed(PI));
				side_s5.diff <= $signed(w_s4 - PI);
				side_s5.mean_lo <= llk_pkg::EXT_W'(meanr_s4 + $signed(PI));
			end else begin
				mean_s5      <= llk_pkg::MEAN_W'(meanr_s4);
				side_s5.diff <= diff_s4;
				side_s5.mean_lo <= llk_pkg::EXT_W'(meanr_s4);
			end
		end
	end

	// ---------------- cordic rotations ----------------
	logic signed [TW-1:0] cx_s [NC];
	logic signed [TW-1:0] cy_s [NC];
	logic signed [TW-1:0] cz_s [NC];
	llk_pkg::side_t       cside_s [NC];

	logic signed [TW-1:0] m30_c;
	assign m30_c = $signed({{(TW-llk_pkg::MEAN_W){1'b0}}, mean_s5}) <<< SH30;

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		logic signed [TW-1:0] xi, yi, zi, at;
		llk_pkg::side_t       si;
		assign at = $signed({2'b00, llk_pkg::atan_q30(i)});
		if (i == 0) begin : g_first
			assign xi = TW'(llk_pkg::CORDIC_GAIN_Q30);
			assign yi = '0;
			assign zi = m30_c - TW'(llk_pkg::HALF_PI_Q30);
			assign si = side_s5;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign si = cside_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cside_s[i] <= si;
				if (!zi[TW-1]) begin
					cx_s[i] <= xi - (yi >>> i);
					cy_s[i] <= yi + (xi >>> i);
					cz_s[i] <= zi - at;
				end else begin
					cx_s[i] <= xi + (yi >>> i);
					cy_s[i] <= yi - (xi >>> i);
					cz_s[i] <= zi + at;
				end
			end
		end
	end

	// ---------------- p1: l1 sin, l1 cos ----------------
	logic signed [TW-1:0] c30_c;
	logic signed [50:0]   l1s_prod, l1c_prod;

	assign c30_c = -cy_s[NC-1];
	assign l1s_prod = $signed({1'b0, upl_q}) * cx_s[NC-1];
	assign l1c_prod = $signed({1'b0, upl_q}) * c30_c;

	logic signed [TW-1:0] l1s_p1, l1c_p1;
	llk_pkg::side_t       side_p1;

	always_ff @(posedge clk) begin
		if (adv) begin
			l1s_p1  <= l1s_prod[49:16];
			l1c_p1  <= l1c_prod[49:16];
			side_p1 <= cside_s[NC-1];
		end
	end

	// ---------------- p2: squares and cross product ----------------
	logic [29:0]          l2_30;
	logic signed [67:0]   sqs_c, psc_c;

	assign l2_30 = {lwl_q, 14'b0};
	assign sqs_c = l1s_p1 * l1s_p1;
	assign psc_c = l1s_p1 * l1c_p1;

	logic [llk_pkg::ARG_W-1:0] sql2_p2;
	logic [61:0]               sqs_p2;
	logic signed [62:0]        psc_p2;
	logic signed [TW-1:0]      l1s_p2, l1c_p2;
	llk_pkg::side_t            side_p2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sql2_p2 <= 60'(l2_30) * 60'(l2_30);
			sqs_p2  <= sqs_c[61:0];
			psc_p2  <= psc_c[62:0];
			l1s_p2  <= l1s_p1;
			l1c_p2  <= l1c_p1;
			side_p2 <= side_p1;
		end
	end

	// ---------------- p3: root argument ----------------
	logic signed [62:0] arg_c;
	assign arg_c = $signed({3'b000, sql2_p2}) - $signed({1'b0, sqs_p2});

	logic [llk_pkg::ARG_W-1:0] arg_p3;
	llk_pkg::mid_t             mid_p3;

	always_ff @(posedge clk) begin
		if (adv) begin
			arg_p3      <= arg_c[llk_pkg::ARG_W-1:0];
			mid_p3.neg  <= arg_c[62];
			mid_p3.psc  <= psc_p2;
			mid_p3.l1s  <= l1s_p2;
			mid_p3.l1c  <= l1c_p2;
			mid_p3.side <= side_p2;
		end
	end

	// ---------------- integer root, one bit per stage ----------------
	logic [RW-1:0]             qr_s [RW];
	logic [32:0]               qrem_s [RW];
	logic [llk_pkg::ARG_W-1:0] qarg_s [RW];
	llk_pkg::mid_t             qmid_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [RW-1:0]             rin;
		logic [32:0]               remin, remn, trial;
		logic [llk_pkg::ARG_W-1:0] ain;
		llk_pkg::mid_t             min_k;
		if (k == 0) begin : g_first
			assign rin = '0;
			assign remin = '0;
			assign ain = arg_p3;
			assign min_k = mid_p3;
		end else begin : g_next
			assign rin = qr_s[k-1];
			assign remin = qrem_s[k-1];
			assign ain = qarg_s[k-1];
			assign min_k = qmid_s[k-1];
		end
		assign remn = {remin[30:0], ain[llk_pkg::ARG_W-1-2*k -: 2]};
		assign trial = {1'b0, rin, 2'b01};
		always_ff @(posedge clk) begin
			if (adv) begin
				qarg_s[k] <= ain;
				qmid_s[k] <= min_k;
				if (remn >= trial) begin
					qrem_s[k] <= remn - trial;
					qr_s[k]   <= {rin[RW-2:0], 1'b1};
				end else begin
					qrem_s[k] <= remn;
					qr_s[k]   <= {rin[RW-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- e1: extension, fault, divider setup ----------------
	llk_pkg::mid_t        mid_e;
	logic [RW-1:0]        root_c;
	logic signed [35:0]   ext30_c, extr_c;
	logic [llk_pkg::EXT_W-1:0] extq_c;
	logic signed [62:0]   pabs_c;

	assign mid_e = qmid_s[RW-1];
	assign root_c = qr_s[RW-1];
	assign ext30_c = $signed({6'b0, root_c}) - 36'(mid_e.l1c);
	assign extr_c = (ext30_c + 36'sd8192) >>> 14;
	// round half up, clamp to the field
	assign extq_c = extr_c[35] ? '0 :
		(extr_c > 36'sd262143) ? '1 : extr_c[llk_pkg::EXT_W-1:0];
	assign pabs_c = mid_e.psc[62] ? -mid_e.psc : mid_e.psc;

	logic [NW-1:0]  num_e1;
	llk_pkg::tail_t tail_e1;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_e1        <= pabs_c[NW-1:0];
			tail_e1.root  <= root_c;
			tail_e1.psgn  <= mid_e.psc[62];
			tail_e1.fault <= mid_e.neg || (root_c == '0);
			tail_e1.ext   <= extq_c;
			tail_e1.l1s   <= mid_e.l1s;
			tail_e1.side  <= mid_e.side;
		end
	end

	// ---------------- jacobian divider, one quotient bit per stage ----------------
	logic [NW-1:0]  dq_s [NW];
	logic [RW-1:0]  drem_s [NW];
	logic [NW-1:0]  dnum_s [NW];
	llk_pkg::tail_t dtail_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [NW-1:0]  qin, nin;
		logic [RW-1:0]  remin;
		logic [RW:0]    remn;
		llk_pkg::tail_t tin;
		if (k == 0) begin : g_first
			assign qin = '0;
			assign remin = '0;
			assign nin = num_e1;
			assign tin = tail_e1;
		end else begin : g_next
			assign qin = dq_s[k-1];
			assign remin = drem_s[k-1];
			assign nin = dnum_s[k-1];
			assign tin = dtail_s[k-1];
		end
		assign remn = {remin, nin[NW-1-k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				dnum_s[k]  <= nin;
				dtail_s[k] <= tin;
				if (remn >= {1'b0, tin.root}) begin
					drem_s[k] <= RW'(remn - {1'b0, tin.root});
					dq_s[k]   <= {qin[NW-2:0], 1'b1};
				end else begin
					drem_s[k] <= remn[RW-1:0];
					dq_s[k]   <= {qin[NW-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- j1: jacobian ----------------
	llk_pkg::tail_t     tail_d;
	logic signed [63:0] qsg_c;
	logic signed [64:0] jac_c;
	logic [63:0]        aj_c;

	assign tail_d = dtail_s[NW-1];
	// quotient truncated toward zero
	assign qsg_c = tail_d.psgn ? -$signed({2'b00, dq_s[NW-1]}) : $signed({2'b00, dq_s[NW-1]});
	assign jac_c = 65'(tail_d.l1s) - 65'(qsg_c);
	assign aj_c = jac_c[64] ? 64'(-jac_c) : jac_c[63:0];

	logic [63:0]    aj_j1;
	logic [AW-1:0]  af_j1;
	logic           sg_j1;
	llk_pkg::tail_t tail_j1;

	always_ff @(posedge clk) begin
		if (adv) begin
			aj_j1   <= aj_c;
			af_j1   <= tail_d.side.fe[AW-1] ? AW'(-tail_d.side.fe) : tail_d.side.fe;
			sg_j1   <= jac_c[64] ^ tail_d.side.fe[AW-1];
			tail_j1 <= tail_d;
		end
	end

	// ---------------- f1: partial products of jacobian by force ----------------
	logic [55:0]    pl_f1, ph_f1;
	logic           sg_f1;
	llk_pkg::tail_t tail_f1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_f1   <= 56'(aj_j1[31:0]) * 56'(af_j1);
			ph_f1   <= 56'(aj_j1[63:32]) * 56'(af_j1);
			sg_f1   <= sg_j1;
			tail_f1 <= tail_j1;
		end
	end

	// ---------------- f2: mean force ----------------
	logic [87:0]        pf_c;
	logic               sat_c;
	logic signed [63:0] sp_c;
	logic signed [34:0] fm_c, fsel_c;

	assign pf_c = {ph_f1, 32'b0} + {32'b0, pl_f1};
	assign sat_c = pf_c > (88'd1 << 62);
	assign sp_c = sg_f1 ? -$signed(pf_c[63:0]) : $signed(pf_c[63:0]);
	assign fm_c = sat_c ? (sg_f1 ? -35'sd8589934592 : 35'sd8589934592) : 35'(sp_c >>> 30);
	assign fsel_c = !mode_q ? 35'(tail_f1.side.fe) : (tail_f1.fault ? '0 : fm_c);

	logic signed [34:0]        fm_f2;
	logic [llk_pkg::EXT_W-1:0] ext_f2;
	logic                      fault_f2;
	llk_pkg::side_t            side_f2;

	always_ff @(posedge clk) begin
		if (adv) begin
			fm_f2    <= fsel_c;
			ext_f2   <= !mode_q ? tail_f1.side.mean_lo : (tail_f1.fault ? '0 : tail_f1.ext);
			fault_f2 <= mode_q && tail_f1.fault;
			side_f2  <= tail_f1.side;
		end
	end

	// ---------------- output register: torques ----------------
	logic signed [35:0] t1_c, t2_c;

	assign t1_c = 36'(fm_f2) + 36'(side_f2.fa);
	assign t2_c = 36'(fm_f2) - 36'(side_f2.fa);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {5'b0, fault_f2, llk_pkg::sat32(t2_c), llk_pkg::sat32(t1_c),
				side_f2.diff, ext_f2};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/llk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llk_checker
// port-level checks on the leg linkage kinematics top level
// ----------------------------------------------------------------------------
module llk_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [111:0] m_tdata
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// input side frees up exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output flow");

	// padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[111:107] == 5'b0)
		else $error("padding bits set");

	// a faulted result reports zero extension
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[106] |-> m_tdata[17:0] == 18'd0)
		else $error("fault with nonzero extension");

endmodule

bind leg_linkage_kinematics_top llk_checker u_llk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/leg_linkage_kinematics_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_linkage_kinematics_top_tb
// self-checking bench for the leg kinematics pipe: an in-bench fixed-point
// predictor forms each expected result, random handshake gaps on both sides,
// one long output hold-off to fill the pipe, several link and mode settings
// ----------------------------------------------------------------------------
module leg_linkage_kinematics_top_tb;

	localparam int FRAC = 16;
	localparam int STAGES = 18;
	localparam int LATENCY = STAGES + 105;
	localparam int N_RANDOM = 1350;

	typedef struct packed {
		logic signed [23:0] ang_a;
		logic signed [23:0] ang_b;
		logic signed [23:0] f_ext;
		logic signed [23:0] f_ang;
	} leg_cmd_t;

	typedef struct packed {
		logic [17:0]        ext;
		logic signed [23:0] angle;
		logic [31:0]        trq1;
		logic [31:0]        trq2;
		logic               fault;
	} toe_out_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [95:0] s_tdata;
	logic [111:0] m_tdata;
	logic cfg_wen;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// predictor copy of the link registers
	longint l1_len, l2_len;
	bit len_mode;

	leg_cmd_t cmd_q[$];
	toe_out_t toe_expect_q[$];
	int n_errors, n_results, n_faults, n_cmds_sent;
	int hold_cycles;

	leg_linkage_kinematics_top #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// floor shift right
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat_trq(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// kinematics of one command under the current link setup
	function automatic toe_out_t leg_kinematics(leg_cmd_t c);
		toe_out_t o;
		longint pi_f, a, b, fe, fa, diff, mean, fmean, ext, w;
		longint x, y, z, dx, dy, l1s, l1c, l2q, arg, root, jac;
		longint unsigned aj, af;
		bit flt;
		pi_f = (llk_pkg::PI_Q32 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
		a = c.ang_a; b = c.ang_b; fe = c.f_ext; fa = c.f_ang;
		diff = fshr(a - b, 1);
		mean = (b + diff) % pi_f;
		fmean = fe; ext = 0; flt = 0;
		if (mean < 0) begin
			w = (diff + 2 * pi_f) % (2 * pi_f);
			if (w < 0) w += 2 * pi_f;
			mean += pi_f;
			diff = w - pi_f;
		end
		if (len_mode) begin
			x = llk_pkg::CORDIC_GAIN_Q30; y = 0;
			z = (mean <<< (30 - FRAC)) - llk_pkg::HALF_PI_Q30;
			for (int i = 0; i < STAGES; i++) begin
				dx = fshr(y, i); dy = fshr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(llk_pkg::atan_q30(i));
				end else begin
					x += dx; y -= dy; z += longint'(llk_pkg::atan_q30(i));
				end
			end
			l1s = fshr(l1_len * x, 16);
			l1c = fshr(l1_len * -y, 16);
			l2q = l2_len <<< 14;
			arg = l2q * l2q - l1s * l1s;
			if (arg < 0) begin
				flt = 1;
			end else begin
				root = int_sqrt(arg);
				ext = fshr(root - l1c + (64'sd1 <<< 13), 14);
				if (ext < 0) ext = 0;
				if (ext > 262143) ext = 262143;
				if (root == 0) begin
					flt = 1;
				end else begin
					jac = l1s - (l1s * l1c) / root;
					aj = jac < 0 ? -jac : jac;
					af = fe < 0 ? -fe : fe;
					if (af != 0 && aj > (64'd1 << 62) / af)
						fmean = ((jac < 0) != (fe < 0)) ? -(64'sd1 <<< 33) : (64'sd1 <<< 33);
					else
						fmean = fshr(jac * fe, 30);
				end
			end
			if (flt) begin
				ext = 0; fmean = 0;
			end
		end else begin
			ext = mean;
		end
		o.ext = ext[17:0];
		o.angle = diff[23:0];
		o.trq1 = 32'(sat_trq(fmean + fa));
		o.trq2 = 32'(sat_trq(fmean - fa));
		o.fault = flt;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
		n_errors++;
	endtask

	// driver: pops the pending queue, random gap before each transaction
	int gap_in;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_in = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) n_cmds_sent++;
			if (gap_in > 0) begin
				gap_in--;
				s_tvalid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				leg_cmd_t c;
				c = cmd_q.pop_front();
				// expectation formed at hand-off under the current setup
				toe_expect_q.push_back(leg_kinematics(c));
				s_tdata <= {c.f_ang, c.f_ext, c.ang_b, c.ang_a};
				s_tvalid <= 1'b1;
				gap_in = $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0) gap_in = 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready: random stalls, or a long hold-off when requested
	int gap_out;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			gap_out = 0;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (gap_out > 0) begin
			gap_out--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid && m_tready) gap_out = $urandom_range(0, 3);
		end
	end

	// monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			toe_out_t got, want;
			got = {m_tdata[17:0], m_tdata[41:18], m_tdata[73:42], m_tdata[105:74], m_tdata[106]};
			if (toe_expect_q.size() == 0) begin
				$display("unexpected output transaction");
				n_errors++;
			end else begin
				want = toe_expect_q.pop_front();
				if (got.ext !== want.ext) report_mismatch("toe_extension", got.ext, want.ext);
				if (got.angle !== want.angle) report_mismatch("toe_angle", got.angle, want.angle);
				if (got.trq1 !== want.trq1)
					report_mismatch("torque_first", $signed(got.trq1), $signed(want.trq1));
				if (got.trq2 !== want.trq2)
					report_mismatch("torque_second", $signed(got.trq2), $signed(want.trq2));
				if (got.fault !== want.fault) report_mismatch("fault", got.fault, want.fault);
				if (m_tdata[111:107] !== 5'd0) report_mismatch("pad bits", m_tdata[111:107], 0);
				if (want.fault) n_faults++;
			end
			n_results++;
		end
	end

	task automatic write_link_reg(llk_pkg::cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			llk_pkg::REG_UPPER_LEN: l1_len = val;
			llk_pkg::REG_LOWER_LEN: l2_len = val;
			llk_pkg::REG_LENGTH_MODE: len_mode = val[0];
			default: ;
		endcase
	endtask

	// wait until the pipe has drained and every expected result is checked, then idle
	task automatic drain_pipe();
		wait (cmd_q.size() == 0 && !s_tvalid && toe_expect_q.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand24();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_angle();
		// mostly angles within a few turns so every fold branch is hit
		if ($urandom_range(0, 3) == 0) return rand24();
		return $signed(24'($urandom_range(0, 1647000))) - 24'sd823500;
	endfunction

	task automatic push_random(int n);
		leg_cmd_t c;
		for (int i = 0; i < n; i++) begin
			c.ang_a = rand_angle();
			c.ang_b = rand_angle();
			c.f_ext = rand24();
			c.f_ang = rand24();
			cmd_q.push_back(c);
		end
	endtask

	task automatic push_cmd(int a, int b, int fe, int fa);
		leg_cmd_t c;
		c.ang_a = 24'(a); c.ang_b = 24'(b); c.f_ext = 24'(fe); c.f_ang = 24'(fa);
		cmd_q.push_back(c);
	endtask

	// directed set: field extremes, fold branches, near-zero root
	task automatic push_directed();
		push_cmd(0, 0, 0, 0);
		push_cmd(8388607, -8388608, 8388607, -8388608);
		push_cmd(-8388608, 8388607, -8388608, 8388607);
		push_cmd(8388607, 8388607, 8388607, 8388607);
		push_cmd(-8388608, -8388608, -8388608, -8388608);
		push_cmd(102944, 102944, 65536, 65536);     // mean near pi/2
		push_cmd(-1, -1, 1, -1);                    // mean just below zero
		push_cmd(205887, 0, 8388607, 8388607);       // mean around pi/2
		push_cmd(-205887, 0, -8388608, 8388607);
		push_cmd(51472, 51472, 8388607, -8388608);
		push_cmd(411775, -411775, 1000, 2000);
		push_cmd(1, 0, -1, 1);
	endtask

	typedef struct {
		logic [15:0] up;
		logic [15:0] lo;
		logic        mode;
	} link_setup_t;

	initial begin
		link_setup_t setups[$];
		int per_phase;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = llk_pkg::REG_UPPER_LEN;
		cfg_data = '0;
		hold_cycles = 0;
		n_errors = 0; n_results = 0; n_faults = 0; n_cmds_sent = 0;
		l1_len = 6554; l2_len = 13107; len_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup first, mean angle mode
		push_directed();
		push_random(150);
		@(posedge clk);
		hold_cycles = 300;  // sender keeps offering, pipe fills and stalls input
		drain_pipe();

		setups = '{
			'{16'd6554, 16'd13107, 1'b1},
			'{16'd1, 16'd1, 1'b1},
			'{16'd65535, 16'd65535, 1'b1},
			'{16'd65535, 16'd1, 1'b1},        // root argument mostly negative
			'{16'd1, 16'd65535, 1'b1},
			'{16'd30000, 16'd30000, 1'b1},    // root reaches zero near pi/2
			'{16'd20000, 16'd45000, 1'b0}};
		per_phase = 135;
		foreach (setups[k]) begin
			write_link_reg(llk_pkg::REG_UPPER_LEN, setups[k].up);
			write_link_reg(llk_pkg::REG_LOWER_LEN, setups[k].lo);
			write_link_reg(llk_pkg::REG_LENGTH_MODE, {15'd0, setups[k].mode});
			if (setups[k].mode) push_directed();
			push_random(per_phase);
			drain_pipe();
		end
		// random link lengths to finish
		for (int k = 0; k < 3; k++) begin
			write_link_reg(llk_pkg::REG_UPPER_LEN, 16'($urandom_range(1, 65535)));
			write_link_reg(llk_pkg::REG_LOWER_LEN, 16'($urandom_range(1, 65535)));
			write_link_reg(llk_pkg::REG_LENGTH_MODE, 16'd1);
			push_random(60);
			drain_pipe();
		end

		$display("sent %0d commands, checked %0d transactions over several link setups",
			n_cmds_sent, n_results);
		$display("%0d of them with fault set, one long output hold-off included", n_faults);
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(20 * 200000);
		$display("timeout, %0d expectations left", toe_expect_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
